/* rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held
`define LEBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge out of reset
`define LEBC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/lebc_pkg.sv */
// Package: constants and interface structs of the LEB128 varint codec
package lebc_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int WORD_BITS_DEF = 64;
    localparam int BYTE_BITS     = 8;
    localparam int GROUP_BITS    = 7;
    localparam int CONT_POS      = 7;
    localparam int SIGN_POS      = 6;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic                 busy;
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } t_enc_out;

    typedef struct packed {
        logic                  fire;
        logic [VALUE_BITS-1:0] word;
        logic                  ovf;
    } t_dec_out;

endpackage

/* rtl/lebc_enc.sv */
// Encoder: shifts the word out one 7-bit group per cycle while i_advance is high
module lebc_enc #(
    parameter int WORD_BITS = lebc_pkg::WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_BITS-1:0]  i_value,
    input  logic                  i_signed_form,
    input  logic                  i_advance,
    output lebc_pkg::t_enc_out    o_res
);

    localparam int GB = lebc_pkg::GROUP_BITS;

    logic                    r_busy;
    logic [WORD_BITS-1:0]    r_word;
    logic                    w_fill;
    logic [WORD_BITS+GB-1:0] w_ext;
    logic [GB-1:0]           w_grp;
    logic [WORD_BITS-1:0]    n_word;
    logic                    w_done;

    // signed form: arithmetic shift, the top bit stays the sign
    assign w_fill = i_signed_form & r_word[WORD_BITS-1];
    assign w_ext  = {{GB{w_fill}}, r_word};
    assign w_grp  = w_ext[GB-1:0];
    assign n_word = w_ext[WORD_BITS+GB-1:GB];

    always_comb begin
        if (i_signed_form) begin
            w_done = ((n_word == '0) && !w_grp[lebc_pkg::SIGN_POS]) ||
                     ((&n_word) && w_grp[lebc_pkg::SIGN_POS]);
        end else begin
            w_done = (n_word == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && i_advance && w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_value;
        end else if (r_busy && i_advance) begin
            r_word <= n_word;
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.data = {~w_done, w_grp};
    assign o_res.last = w_done;

endmodule

/* rtl/lebc_dec.sv */
// Decoder: drops each 7-bit group into its slot of the accumulator
module lebc_dec #(
    parameter int WORD_BITS = lebc_pkg::WORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lebc_pkg::BYTE_BITS-1:0]   i_byte,
    input  logic                             i_signed_form,
    output lebc_pkg::t_dec_out               o_res
);

    localparam int GB = lebc_pkg::GROUP_BITS;
    localparam int NG = (WORD_BITS + GB - 1) / GB;
    localparam int CW = $clog2(NG + 1);

    logic [WORD_BITS-1:0] r_acc;
    logic [CW-1:0]        r_grp;
    logic                 r_ovf;
    logic [WORD_BITS-1:0] w_place;
    logic [WORD_BITS-1:0] w_fill;
    logic [WORD_BITS-1:0] n_acc;
    logic [WORD_BITS-1:0] w_word;
    logic                 w_drop;
    logic                 w_final;

    for (genvar g = 0; g < WORD_BITS; g++) begin : g_bit
        localparam int GI = g / GB;
        localparam int BI = g % GB;
        assign w_place[g] = (r_grp == CW'(GI)) & i_byte[BI];
        // ones above the last group when its sign bit is set
        assign w_fill[g]  = (r_grp < CW'(GI)) & i_byte[lebc_pkg::SIGN_POS];
    end

    assign w_drop  = (r_grp >= CW'(NG));
    assign w_final = ~i_byte[lebc_pkg::CONT_POS];
    assign n_acc   = r_acc | w_place;
    assign w_word  = n_acc | (i_signed_form ? w_fill : '0);

    for (genvar j = 0; j < lebc_pkg::VALUE_BITS; j++) begin : g_ext
        if (j < WORD_BITS) begin : g_in
            assign o_res.word[j] = w_word[j];
        end else begin : g_sx
            assign o_res.word[j] = i_signed_form & w_word[WORD_BITS-1];
        end
    end

    assign o_res.fire = i_start & w_final;
    assign o_res.ovf  = r_ovf | w_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_grp <= '0;
            r_ovf <= 1'b0;
        end else if (i_start) begin
            if (w_final) begin
                r_acc <= '0;
                r_grp <= '0;
                r_ovf <= 1'b0;
            end else if (w_drop) begin
                r_ovf <= 1'b1;
            end else begin
                r_acc <= n_acc;
                r_grp <= r_grp + CW'(1);
            end
        end
    end

endmodule

/* rtl/leb128_varint_codec.sv */
// Top level: LEB128 varint codec, unsigned or signed form
//
// Input channel (i_in_valid / o_in_stall) carries an opcode, a 64-bit value
// and one encoded byte. Encode takes the value and returns its 7-bit groups
// as bytes, low group first, bit 7 set on all but the last, o_last on the
// final one. Decode takes one byte per transfer and returns the word once a
// byte with bit 7 clear arrives, with o_overflow if groups fell past the word.
// Output channel (o_out_valid / i_out_stall) is one output register.
// Encode: the item is taken into the encoder shift register, which then
// hands one byte per cycle to the output register while the receiver does
// not stall. Decode: one byte per cycle while the input channel does not
// stall; the result is registered in the cycle after the last byte.
// o_cfg_ready is always high; write signed_form only while idle.
// Reset clears the form register, the encoder busy flag, the decoder and the output valid flag.
// A stalled receiver freezes the output register and the encoder shift
// register; the input channel stalls until a slot is free again.
module leb128_varint_codec #(
    parameter int WORD_BITS = lebc_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [lebc_pkg::VALUE_BITS-1:0]   i_value,
    input  logic [lebc_pkg::BYTE_BITS-1:0]    i_in_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lebc_pkg::BYTE_BITS-1:0]    o_out_byte,
    output logic [lebc_pkg::VALUE_BITS-1:0]   o_decoded_value,
    output logic                              o_is_decoded,
    output logic                              o_last,
    output logic                              o_overflow
);

    logic                r_signed_form;
    logic                r_out_valid;
    logic                w_out_free;
    logic                w_accept;
    lebc_pkg::t_enc_out  w_enc;
    lebc_pkg::t_dec_out  w_dec;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = ~r_out_valid | ~i_out_stall;
    assign o_in_stall  = w_enc.busy | ~w_out_free;
    assign w_accept    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_form <= 1'b0;
        end else if (i_cfg_valid) begin
            r_signed_form <= i_cfg_data;
        end
    end

    lebc_enc #(
        .WORD_BITS (WORD_BITS)
    ) u_enc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_accept && (i_opcode == lebc_pkg::OP_ENCODE)),
        .i_value       (i_value[WORD_BITS-1:0]),
        .i_signed_form (r_signed_form),
        .i_advance     (w_out_free),
        .o_res         (w_enc)
    );

    lebc_dec #(
        .WORD_BITS (WORD_BITS)
    ) u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_accept && (i_opcode == lebc_pkg::OP_DECODE)),
        .i_byte        (i_in_byte),
        .i_signed_form (r_signed_form),
        .o_res         (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_enc.busy && w_out_free) || w_dec.fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enc.busy && w_out_free) begin
            o_out_byte      <= w_enc.data;
            o_decoded_value <= '0;
            o_is_decoded    <= 1'b0;
            o_last          <= w_enc.last;
            o_overflow      <= 1'b0;
        end else if (w_dec.fire) begin
            o_out_byte      <= '0;
            o_decoded_value <= w_dec.word;
            o_is_decoded    <= 1'b1;
            o_last          <= 1'b1;
            o_overflow      <= w_dec.ovf;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/lebc_checker.sv */
// Port-level checker for the LEB128 varint codec, bound to the top level
`include "assert_macros.svh"

module lebc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_opcode,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [lebc_pkg::BYTE_BITS-1:0]    o_out_byte,
    input logic [lebc_pkg::VALUE_BITS-1:0]   o_decoded_value,
    input logic                              o_is_decoded,
    input logic                              o_last,
    input logic                              o_overflow
);

    `LEBC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_byte) && $stable(o_decoded_value)), "stalled result changed")

    `LEBC_ASSERT(a_dec_shape, i_clk, i_rst_n, (o_out_valid && o_is_decoded) |-> (o_last && (o_out_byte == '0)), "decode result not flagged last or carries a byte")

    `LEBC_NEVER(a_enc_clean, i_clk, i_rst_n, o_out_valid && !o_is_decoded && (o_overflow || (o_decoded_value != '0)), "encoded byte carries decode fields")

    `LEBC_ASSERT(a_enc_cont, i_clk, i_rst_n, (o_out_valid && !o_is_decoded) |-> (o_out_byte[lebc_pkg::CONT_POS] == !o_last), "continuation bit disagrees with last")

    `LEBC_ASSERT(a_enc_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall && (i_opcode == lebc_pkg::OP_ENCODE)) |=> o_in_stall, "input taken while encoder busy")

endmodule

bind leb128_varint_codec lebc_checker u_lebc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_opcode        (i_opcode),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_byte      (o_out_byte),
    .o_decoded_value (o_decoded_value),
    .o_is_decoded    (o_is_decoded),
    .o_last          (o_last),
    .o_overflow      (o_overflow)
);

/* tb/sv/tb_leb128_varint_codec.sv */
// Testbench for the LEB128 varint codec: directed and random transfers checked field by field
module tb_leb128_varint_codec;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [lebc_pkg::BYTE_BITS-1:0]  enc_byte;
        logic [lebc_pkg::VALUE_BITS-1:0] word;
        logic                            is_decoded;
        logic                            last;
        logic                            overflow;
    } t_codec_result;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            i_cfg_data  = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            i_opcode    = lebc_pkg::OP_ENCODE;
    logic [lebc_pkg::VALUE_BITS-1:0] i_value     = '0;
    logic [lebc_pkg::BYTE_BITS-1:0]  i_in_byte   = '0;
    logic                            i_out_stall = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [lebc_pkg::BYTE_BITS-1:0]  o_out_byte;
    logic [lebc_pkg::VALUE_BITS-1:0] o_decoded_value;
    logic                            o_is_decoded;
    logic                            o_last;
    logic                            o_overflow;

    // predictor state
    logic                            form_signed = 1'b0;
    logic [lebc_pkg::VALUE_BITS-1:0] dec_acc     = '0;
    logic [6:0]                      dec_shift   = '0;
    logic                            dec_ovf     = 1'b0;
    logic [lebc_pkg::BYTE_BITS-1:0]  enc_groups [16];

    t_codec_result results_due [$];
    t_codec_result due_head;
    int            mismatches     = 0;
    int            items_sent     = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    leb128_varint_codec i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_decoded_value (o_decoded_value),
        .o_is_decoded    (o_is_decoded),
        .o_last          (o_last),
        .o_overflow      (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Splits a word into 7-bit groups in the current form; returns the byte count
    function automatic int encode_groups(input logic [lebc_pkg::VALUE_BITS-1:0] val);
        logic [lebc_pkg::VALUE_BITS-1:0] rest;
        logic [lebc_pkg::BYTE_BITS-1:0]  grp;
        logic                            done;
        int                              n;
        rest = val;
        n    = 0;
        done = 1'b0;
        while (!done && n < 10) begin
            grp = {1'b0, rest[lebc_pkg::GROUP_BITS-1:0]};
            if (form_signed) begin
                rest = $signed(rest) >>> lebc_pkg::GROUP_BITS;
                done = (rest == '0 && !grp[lebc_pkg::SIGN_POS]) ||
                       (rest == '1 && grp[lebc_pkg::SIGN_POS]);
            end else begin
                rest = rest >> lebc_pkg::GROUP_BITS;
                done = (rest == '0);
            end
            grp[lebc_pkg::CONT_POS] = !done;
            enc_groups[n] = grp;
            n++;
        end
        return n;
    endfunction

    task automatic predict_codec_output(input logic op,
                                        input logic [lebc_pkg::VALUE_BITS-1:0] val,
                                        input logic [lebc_pkg::BYTE_BITS-1:0] b);
        t_codec_result                   r;
        logic [lebc_pkg::VALUE_BITS-1:0] word;
        int                              n;
        if (op == lebc_pkg::OP_ENCODE) begin
            n = encode_groups(val);
            for (int k = 0; k < n; k++) begin
                r = '{enc_byte: enc_groups[k], word: '0, is_decoded: 1'b0,
                      last: (k == n - 1), overflow: 1'b0};
                results_due.push_back(r);
            end
        end else begin
            // groups past the top of the word are dropped and flagged
            if (dec_shift < 7'd64) begin
                dec_acc   |= lebc_pkg::VALUE_BITS'(b[lebc_pkg::GROUP_BITS-1:0]) << dec_shift;
                dec_shift += 7'd7;
            end else begin
                dec_ovf = 1'b1;
            end
            if (!b[lebc_pkg::CONT_POS]) begin
                word = dec_acc;
                if (form_signed && b[lebc_pkg::SIGN_POS] && dec_shift < 7'd64)
                    word |= {lebc_pkg::VALUE_BITS{1'b1}} << dec_shift;
                r = '{enc_byte: '0, word: word, is_decoded: 1'b1, last: 1'b1,
                      overflow: dec_ovf};
                results_due.push_back(r);
                dec_acc   = '0;
                dec_shift = '0;
                dec_ovf   = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // One input transfer; valid stays high into the next call unless a gap is drawn
    task automatic send_item(input logic op, input logic [lebc_pkg::VALUE_BITS-1:0] val,
                             input logic [lebc_pkg::BYTE_BITS-1:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_codec_output(op, val, b);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        // a trailing continuation byte leaves nothing to wait on
        repeat (16) @(posedge i_clk);
    endtask

    task automatic load_form(input logic sgn);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sgn;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        form_signed = sgn;
    endtask

    function automatic logic [lebc_pkg::VALUE_BITS-1:0] random_word();
        logic [lebc_pkg::VALUE_BITS-1:0] w;
        w = {$urandom, $urandom} >> $urandom_range(63);
        if ($urandom_range(1))
            w = ~w;
        return w;
    endfunction

    // Well-formed byte stream for a word, sometimes over-long with sign padding
    task automatic send_encoded_word(input logic [lebc_pkg::VALUE_BITS-1:0] w);
        logic [lebc_pkg::BYTE_BITS-1:0] seq [16];
        logic [lebc_pkg::BYTE_BITS-1:0] pad;
        int                             n;
        int                             k;
        n = encode_groups(w);
        for (int i = 0; i < n; i++)
            seq[i] = enc_groups[i];
        if ($urandom_range(4) == 0) begin
            pad = (form_signed && seq[n-1][lebc_pkg::SIGN_POS]) ? 8'hFF : 8'h80;
            seq[n-1][lebc_pkg::CONT_POS] = 1'b1;
            k = $urandom_range(1, 15 - n);
            for (int i = 0; i < k; i++)
                seq[n+i] = pad;
            seq[n+k] = pad & 8'h7F;
            n = n + k + 1;
        end
        for (int i = 0; i < n; i++)
            send_item(lebc_pkg::OP_DECODE, random_word(), seq[i]);
    endtask

    task automatic send_noise();
        if ($urandom_range(9) == 0) begin
            repeat (12) send_item(lebc_pkg::OP_DECODE, random_word(), 8'($urandom) | 8'h80);
        end
        repeat ($urandom_range(1, 4)) send_item(lebc_pkg::OP_DECODE, random_word(), 8'($urandom));
    endtask

    task automatic test_unsigned_extremes();
        send_item(lebc_pkg::OP_ENCODE, 64'h0, 8'h00);
        send_item(lebc_pkg::OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    endtask

    // ten full groups run past bit 63, the eleventh is dropped
    task automatic test_decode_overflow();
        repeat (10) send_item(lebc_pkg::OP_DECODE, 64'h0, 8'hFF);
        send_item(lebc_pkg::OP_DECODE, 64'h0, 8'h7F);
    endtask

    task automatic test_encode_mid_decode_and_form_change();
        send_item(lebc_pkg::OP_DECODE, 64'h0, 8'h85);
        send_item(lebc_pkg::OP_ENCODE, 64'h80, 8'h00);
        wait_idle();
        load_form(1'b1);
        send_item(lebc_pkg::OP_DECODE, 64'h0, 8'h7F);
    endtask

    task automatic test_signed_extremes();
        send_item(lebc_pkg::OP_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
        send_item(lebc_pkg::OP_ENCODE, 64'h8000_0000_0000_0000, 8'h00);
        send_item(lebc_pkg::OP_ENCODE, -64'sd65, 8'h00);
        send_item(lebc_pkg::OP_ENCODE, 64'd64, 8'h00);
        send_item(lebc_pkg::OP_DECODE, 64'h0, 8'h40);
    endtask

    task automatic run_random_phase(input int sender_idle, input int receiver_stall,
                                    input logic sgn, input int n_items);
        int start;
        wait_idle();
        load_form(sgn);
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        start = items_sent;
        while (items_sent - start < n_items) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_item(lebc_pkg::OP_ENCODE, random_word(), 8'($urandom));
                4, 5, 6, 7: send_encoded_word(random_word());
                default:    send_noise();
            endcase
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 1'b0, 25);
        run_random_phase(67, 0, 1'b1, 25);
        run_random_phase(0, 67, 1'b0, 25);
        run_random_phase(27, 27, 1'b1, 25);
    endtask

    // receiver: random stall, and every accepted transfer checked against the oldest due result
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                due_head = results_due.pop_front();
                if (o_out_byte !== due_head.enc_byte)
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              o_out_byte, due_head.enc_byte));
                if (o_decoded_value !== due_head.word)
                    report_mismatch($sformatf("decoded_value %h, expected %h",
                                              o_decoded_value, due_head.word));
                if (o_is_decoded !== due_head.is_decoded)
                    report_mismatch($sformatf("is_decoded %b, expected %b",
                                              o_is_decoded, due_head.is_decoded));
                if (o_last !== due_head.last)
                    report_mismatch($sformatf("last %b, expected %b", o_last, due_head.last));
                if (o_overflow !== due_head.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              o_overflow, due_head.overflow));
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unsigned_extremes();
        test_decode_overflow();
        test_encode_mid_decode_and_form_change();
        test_signed_extremes();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
